[hdl/bmf_pkg.sv]
// Box mean filter package: sizes, derived widths, register codes and the
// queue item passed from the front end to the back end. No dependencies.

package bmf_pkg;

	localparam int WINDOW = 5;
	localparam int MAX_WIDTH = 1024;
	localparam int HALF = WINDOW / 2;
	localparam int TAPS = 2 * HALF + 1;
	localparam int AREA = WINDOW * WINDOW;

	localparam int PIX_W = 8;
	localparam int PIX_MAX = 255;

	localparam int WIDTH_REG_W = 11;
	localparam int HEIGHT_REG_W = 12;
	localparam int CFG_W = 12;
	localparam int CFG_IDX_W = 1;

	localparam int ROW_W = 12;
	localparam int ROW_MAX = 4095;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
	localparam int POS_W = ROW_W + COL_W;

	localparam int LINE_W = (TAPS - 1) * PIX_W;
	localparam int CS_W = $clog2(TAPS * PIX_MAX + 1);
	localparam int SUM_W = $clog2(TAPS * TAPS * PIX_MAX + 1);
	localparam int DIV_SHIFT = SUM_W + $clog2(AREA);
	localparam int RECIP = ((1 << DIV_SHIFT) + AREA - 1) / AREA;
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int PROD_W = SUM_W + RECIP_W;
	localparam int MEAN_W = PROD_W - DIV_SHIFT;

	localparam int WIDTH_RESET_RAW = 640;
	localparam int WIDTH_RESET = (WIDTH_RESET_RAW > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET_RAW;
	localparam int HEIGHT_RESET = 480;
	localparam int LAG_RESET = HALF * WIDTH_RESET + HALF;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic [COL_W-1:0] idx;
		logic             emit;
		logic             interior;
		logic             last;
	} bmf_item_t;

endpackage

[hdl/bmf_ifs.sv]
// Valid/ready channel interfaces for the box mean filter: pixel requests in,
// window means out. Depends on bmf_pkg.

interface bmf_in_if import bmf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_in;
	logic             frame_start;
	logic             flush;

	modport source (output valid, pixel_in, frame_start, flush, input ready);
	modport sink (input valid, pixel_in, frame_start, flush, output ready);
endinterface

interface bmf_out_if import bmf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             frame_last;

	modport source (output valid, pixel_out, frame_last, input ready);
	modport sink (input valid, pixel_out, frame_last, output ready);
endinterface

[hdl/box_mean_filter.sv]
// Box mean filter top level: front end, item queue and back end.
// Depends on bmf_pkg, bmf_ifs, bmf_front, bmf_queue, bmf_back.
//
//   channel  | kind          | payload                         | accepted when
//   pixels   | valid/ready   | pixel_in, frame_start, flush    | valid && ready
//   means    | valid/ready   | pixel_out, frame_last           | valid && ready
//   cfg      | write strobe  | cfg_index, cfg_data             | cfg_write
//
// One pixel request per clock sustained while the output is taken; a result passes
// the queue slot, line store read, column sum, window sum and divide stages and then
// the output register.
// Ready drops for one cycle after an image_width write (row offset multiply).
// The line store needs no clearing pass; reset is ready at once.
// A held output stalls the back end; the 4-entry queue then fills and ready drops.

module box_mean_filter import bmf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	bmf_in_if.sink               pixels,
	bmf_out_if.source            means,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic      push, q_full, pop, head_valid;
	bmf_item_t push_item, head_item;

	bmf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pixels),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	bmf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	bmf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.means      (means)
	);

endmodule

[hdl/bmf_front.sv]
// Front end: configuration registers, input and output position counters,
// classification of each request into a queue item. Depends on bmf_pkg, bmf_ifs.

module bmf_front import bmf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	bmf_in_if.sink               pixels,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 q_full,
	output logic                 push,
	output bmf_item_t            push_item
);

	logic [COL_W-1:0]        col_q, ocol_q;
	logic [ROW_W-1:0]        row_q, orow_q;
	logic [POS_W-1:0]        pos_q, lag_q;
	logic [WEFF_W-1:0]       weff_q;
	logic [HEIGHT_REG_W-1:0] heff_q;
	logic                    done_q;
	logic                    recalc_q;

	logic                    take, fs;
	logic [COL_W-1:0]        col_c, ocol_c, col_n, ocol_n;
	logic [ROW_W-1:0]        row_c, orow_c, row_n, orow_n;
	logic [POS_W-1:0]        pos_c, pos_base, pos_n, recalc_pos, lag_new;
	logic                    done_c, done_n;
	logic                    emit, interior, last, in_wrap, out_wrap, row_sat;
	logic [ROW_W+WEFF_W-1:0] row_prod;
	logic [WIDTH_REG_W-1:0]  wv;
	logic [HEIGHT_REG_W-1:0] hv, heff_new;
	logic [WEFF_W-1:0]       weff_new;

	assign pixels.ready = !recalc_q && !q_full;
	assign take = pixels.valid && pixels.ready;
	assign fs = pixels.frame_start;

	always_comb begin
		col_c  = fs ? '0 : col_q;
		row_c  = fs ? '0 : row_q;
		ocol_c = fs ? '0 : ocol_q;
		orow_c = fs ? '0 : orow_q;
		pos_c  = fs ? '0 : pos_q;
		done_c = fs ? 1'b0 : done_q;

		emit = !done_c && (pos_c >= lag_q);
		interior = (int'(orow_c) >= HALF) && (int'(orow_c) + HALF < int'(heff_q)) &&
			(int'(ocol_c) >= HALF) && (int'(ocol_c) + HALF < int'(weff_q));
		last = (int'(orow_c) + 1 >= int'(heff_q)) && (int'(ocol_c) + 1 >= int'(weff_q));

		in_wrap = int'(col_c) + 1 >= int'(weff_q);
		row_sat = (row_c == ROW_W'(ROW_MAX));
		col_n = in_wrap ? '0 : col_c + 1'b1;
		row_n = (in_wrap && !row_sat) ? row_c + 1'b1 : row_c;
		pos_base = pos_c - POS_W'(col_c);
		if (!in_wrap) begin
			pos_n = pos_c + 1'b1;
		end else if (row_sat) begin
			pos_n = pos_base;
		end else begin
			pos_n = pos_base + POS_W'(weff_q);
		end

		out_wrap = int'(ocol_c) + 1 >= int'(weff_q);
		ocol_n = ocol_c;
		orow_n = orow_c;
		done_n = done_c;
		if (emit) begin
			if (last) begin
				done_n = 1'b1;
			end else if (out_wrap) begin
				ocol_n = '0;
				if (orow_c != ROW_W'(ROW_MAX)) begin
					orow_n = orow_c + 1'b1;
				end
			end else begin
				ocol_n = ocol_c + 1'b1;
			end
		end
	end

	always_comb begin
		wv = cfg_data[WIDTH_REG_W-1:0];
		hv = cfg_data[HEIGHT_REG_W-1:0];
		if (wv == '0) begin
			weff_new = WEFF_W'(1);
		end else if (int'(wv) > MAX_WIDTH) begin
			weff_new = WEFF_W'(MAX_WIDTH);
		end else begin
			weff_new = WEFF_W'(wv);
		end
		heff_new = (hv == '0) ? HEIGHT_REG_W'(1) : hv;
		lag_new = POS_W'(HALF * int'(weff_new) + HALF);
		row_prod = (ROW_W+WEFF_W)'(row_q) * (ROW_W+WEFF_W)'(weff_q);
		recalc_pos = POS_W'(row_prod + (ROW_W+WEFF_W)'(col_q));
	end

	assign push = take;
	assign push_item.pix = pixels.flush ? '0 : pixels.pixel_in;
	assign push_item.idx = col_c;
	assign push_item.emit = emit;
	assign push_item.interior = interior;
	assign push_item.last = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
			pos_q    <= '0;
			done_q   <= 1'b0;
			weff_q   <= WEFF_W'(WIDTH_RESET);
			heff_q   <= HEIGHT_REG_W'(HEIGHT_RESET);
			lag_q    <= POS_W'(LAG_RESET);
			recalc_q <= 1'b0;
		end else begin
			recalc_q <= 1'b0;
			if (cfg_write) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_WIDTH: begin
						weff_q   <= weff_new;
						lag_q    <= lag_new;
						recalc_q <= 1'b1;
					end
					REG_HEIGHT: begin
						heff_q <= heff_new;
					end
				endcase
			end
			if (recalc_q) begin
				pos_q <= recalc_pos;
			end
			if (take) begin
				col_q  <= col_n;
				row_q  <= row_n;
				pos_q  <= pos_n;
				ocol_q <= ocol_n;
				orow_q <= orow_n;
				done_q <= done_n;
			end
		end
	end

endmodule

[hdl/bmf_queue.sv]
// Short queue of classified items between the front end and the back end.
// Depends on bmf_pkg.

module bmf_queue import bmf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  bmf_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output bmf_item_t head_item
);

	bmf_item_t             slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wp_q, rp_q;
	logic [QUEUE_AW:0]     cnt_q;
	logic                  do_pop;

	assign full = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item = slot_q[rp_q];
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[hdl/bmf_back.sv]
// Back end: line store, column sums, window sum, divide by the window
// area and the output register. Depends on bmf_pkg, bmf_ifs.

module bmf_back import bmf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  bmf_item_t head_item,
	output logic      pop,
	bmf_out_if.source means
);

	localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

	logic [LINE_W-1:0] line_mem [MAX_WIDTH];
	logic [LINE_W-1:0] rd_raw_q, fwd_data_q;
	logic              fwd_hit_q;

	logic              adv;
	logic              wr_en;
	logic [LINE_W-1:0] line_c, wr_data;
	logic [CS_W-1:0]   colsum;
	logic [SUM_W-1:0]  win_sum_c;
	logic [MEAN_W-1:0] quot;
	logic [PIX_W-1:0]  mean_c;

	logic              valid_s1, valid_s2, em_s3, em_s4, out_valid_q;
	bmf_item_t         item_s1;
	logic [CS_W-1:0]   colsum_s2;
	logic              emit_s2, interior_s2, last_s2;
	logic              interior_s3, last_s3, interior_s4, last_s4;
	logic [PROD_W-1:0] prod_s4;
	logic [CS_W-1:0]   cs_q [TAPS-1];
	logic [SUM_W-1:0]  win_sum_q;
	logic [PIX_W-1:0]  pixel_out_q;
	logic              frame_last_q;

	assign adv = !out_valid_q || means.ready;
	assign pop = adv && head_valid;
	assign wr_en = adv && valid_s1;

	assign line_c = fwd_hit_q ? fwd_data_q : rd_raw_q;
	assign wr_data = {line_c[LINE_W-PIX_W-1:0], item_s1.pix};

	always_comb begin
		colsum = CS_W'(item_s1.pix);
		for (int k = 0; k < TAPS - 1; k++) begin
			colsum = colsum + CS_W'(line_c[k*PIX_W +: PIX_W]);
		end
	end

	always_comb begin
		win_sum_c = SUM_W'(colsum_s2);
		for (int k = 0; k < TAPS - 1; k++) begin
			win_sum_c = win_sum_c + SUM_W'(cs_q[k]);
		end
	end

	always_comb begin
		quot = prod_s4[PROD_W-1:DIV_SHIFT];
		if (!interior_s4) begin
			mean_c = '0;
		end else if (int'(quot) > PIX_MAX) begin
			mean_c = PIX_W'(PIX_MAX);
		end else begin
			mean_c = quot[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[item_s1.idx] <= wr_data;
		end
		if (adv) begin
			rd_raw_q   <= line_mem[head_item.idx];
			fwd_hit_q  <= wr_en && (item_s1.idx == head_item.idx);
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1      <= head_item;
			colsum_s2    <= colsum;
			emit_s2      <= item_s1.emit;
			interior_s2  <= item_s1.interior;
			last_s2      <= item_s1.last;
			interior_s3  <= interior_s2;
			last_s3      <= last_s2;
			prod_s4      <= PROD_W'(win_sum_q) * PROD_W'(RECIP_V);
			interior_s4  <= interior_s3;
			last_s4      <= last_s3;
			pixel_out_q  <= mean_c;
			frame_last_q <= last_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			em_s3       <= 1'b0;
			em_s4       <= 1'b0;
			out_valid_q <= 1'b0;
			win_sum_q   <= '0;
			for (int k = 0; k < TAPS - 1; k++) begin
				cs_q[k] <= '0;
			end
		end else if (adv) begin
			valid_s1    <= head_valid;
			valid_s2    <= valid_s1;
			em_s3       <= valid_s2 && emit_s2;
			em_s4       <= em_s3;
			out_valid_q <= em_s4;
			if (valid_s2) begin
				for (int k = 0; k < TAPS - 2; k++) begin
					cs_q[k] <= cs_q[k+1];
				end
				cs_q[TAPS-2] <= colsum_s2;
				win_sum_q <= win_sum_c;
			end
		end
	end

	assign means.valid = out_valid_q;
	assign means.pixel_out = pixel_out_q;
	assign means.frame_last = frame_last_q;

endmodule

[hdl/bmf_checker.sv]
// Port-level checks for the box mean filter, bound to the top level.
// Depends on bmf_pkg, bmf_ifs, box_mean_filter.

module bmf_checker import bmf_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	bmf_in_if.sink              pixels,
	bmf_out_if.source           means,
	input logic                 cfg_write,
	input logic [CFG_IDX_W-1:0] cfg_index
);

	logic [31:0] credit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + 32'(pixels.valid && pixels.ready)
				- 32'(means.valid && means.ready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		means.valid && !means.ready |=> means.valid)
		else $error("output request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		means.valid && !means.ready |=> $stable(means.pixel_out) && $stable(means.frame_last))
		else $error("output payload changed while stalled");

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		means.valid && means.ready |-> credit_q != '0)
		else $error("more results than accepted pixels");

	a_last_border: assert property (@(posedge clk) disable iff (!arst_n)
		means.valid && means.frame_last |-> means.pixel_out == '0)
		else $error("frame corner result not zero");

	a_width_recalc: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write && cfg_index == REG_WIDTH |=> !pixels.ready)
		else $error("pixel accepted during row offset update");

endmodule

bind box_mean_filter bmf_checker u_bmf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pixels    (pixels),
	.means     (means),
	.cfg_write (cfg_write),
	.cfg_index (cfg_index)
);

[bench/tb_top.sv]
// Self-checking bench for box_mean_filter: directed rows, then random frames with
// idle gaps on both channels, each mean checked against an in-bench window model or a fixed value.
// Depends on bmf_pkg and the bmf_in_if / bmf_out_if interfaces.
`timescale 1ns / 100ps

module tb_top;
	import bmf_pkg::*;

	localparam int SETTLE_CYCLES  = 12;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RAND_ITEMS     = 640;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             last;
	} mean_t;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_PIX,
		ROW_PIX_FIXED
	} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		cfg_reg_t         idx;
		logic [CFG_W-1:0] data;
		logic [PIX_W-1:0] pix;
		logic             fs;
		logic             fl;
		bit               made;
		mean_t            res;
	} row_t;

	typedef enum int {
		FILL_RANDOM,
		FILL_WHITE,
		FILL_BLACK,
		FILL_BINARY,
		FILL_BRIGHT
	} fill_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	bmf_in_if  pix_if ();
	bmf_out_if mean_if ();

	box_mean_filter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pix_if),
		.means     (mean_if),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// window model state
	logic [PIX_W-1:0]        line_mem [TAPS-1][MAX_WIDTH];
	logic [PIX_W-1:0]        win_px [TAPS][TAPS];
	int unsigned             src_col, src_row, dst_col, dst_row;
	bit                      frame_over;
	logic [WIDTH_REG_W-1:0]  width_reg;
	logic [HEIGHT_REG_W-1:0] height_reg;

	mean_t       expected_means [$];
	row_t        dir_rows [$];
	int unsigned mismatch_cnt;
	int unsigned cycle_cnt;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit gap_roll();
		if (cycle_cnt >= 1000 && cycle_cnt < 4000)
			return 1'b0;
		return $urandom_range(0, 99) < 18;
	endfunction

	function automatic int unsigned eff_width();
		if (width_reg == 0)
			return 1;
		if (width_reg > MAX_WIDTH)
			return MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg == 0)
			return 1;
		return height_reg;
	endfunction

	function automatic void clear_counters();
		src_col = 0;
		src_row = 0;
		dst_col = 0;
		dst_row = 0;
		frame_over = 1'b0;
	endfunction

	function automatic void reset_window_model();
		int i, j;
		for (i = 0; i < TAPS - 1; i++)
			for (j = 0; j < MAX_WIDTH; j++)
				line_mem[i][j] = '0;
		for (i = 0; i < TAPS; i++)
			for (j = 0; j < TAPS; j++)
				win_px[i][j] = '0;
		clear_counters();
		width_reg = WIDTH_REG_W'(WIDTH_RESET_RAW);
		height_reg = HEIGHT_REG_W'(HEIGHT_RESET);
	endfunction

	function automatic void predict_mean(input logic [PIX_W-1:0] raw, input logic fs,
			input logic fl, output bit made, output mean_t res);
		logic [PIX_W-1:0] px;
		logic [PIX_W-1:0] col [TAPS];
		int unsigned w, h, idx, pos, lag, acc, avg;
		int i, j, k;
		px = fl ? '0 : raw;
		if (fs)
			clear_counters();
		w = eff_width();
		h = eff_height();
		idx = (src_col < MAX_WIDTH) ? src_col : MAX_WIDTH - 1;
		col[0] = px;
		for (k = 0; k < TAPS - 1; k++)
			col[k + 1] = line_mem[k][idx];
		for (k = TAPS - 2; k > 0; k--)
			line_mem[k][idx] = line_mem[k - 1][idx];
		line_mem[0][idx] = px;
		for (i = 0; i < TAPS; i++) begin
			for (j = 0; j < TAPS - 1; j++)
				win_px[i][j] = win_px[i][j + 1];
			win_px[i][TAPS - 1] = col[TAPS - 1 - i];
		end
		made = 1'b0;
		res = '0;
		pos = src_row * w + src_col;
		lag = HALF * w + HALF;
		if (!frame_over && pos >= lag) begin
			avg = 0;
			if (dst_row >= HALF && dst_row + HALF < h &&
					dst_col >= HALF && dst_col + HALF < w) begin
				acc = 0;
				for (i = 0; i < TAPS; i++)
					for (j = 0; j < TAPS; j++)
						acc += win_px[i][j];
				avg = acc / AREA;
				if (avg > PIX_MAX)
					avg = PIX_MAX;
			end
			res.pix = avg[PIX_W-1:0];
			res.last = (dst_row + 1 >= h) && (dst_col + 1 >= w);
			made = 1'b1;
			if (res.last) begin
				frame_over = 1'b1;
			end else if (dst_col + 1 >= w) begin
				dst_col = 0;
				if (dst_row < ROW_MAX)
					dst_row++;
			end else begin
				dst_col++;
			end
		end
		if (src_col + 1 >= w) begin
			src_col = 0;
			if (src_row < ROW_MAX)
				src_row++;
		end else begin
			src_col++;
		end
	endfunction

	function automatic row_t cfg_row(cfg_reg_t idx, logic [CFG_W-1:0] data);
		row_t r;
		r = '{kind: ROW_CFG, idx: REG_WIDTH, default: '0};
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic row_t pix_row(logic [PIX_W-1:0] pix, logic fs, logic fl);
		row_t r;
		r = '{kind: ROW_PIX, idx: REG_WIDTH, default: '0};
		r.pix = pix;
		r.fs = fs;
		r.fl = fl;
		return r;
	endfunction

	function automatic row_t fixed_row(logic [PIX_W-1:0] pix, logic fs, logic fl, bit made,
			logic [PIX_W-1:0] rpix, logic rlast);
		row_t r;
		r = pix_row(pix, fs, fl);
		r.kind = ROW_PIX_FIXED;
		r.made = made;
		r.res.pix = rpix;
		r.res.last = rlast;
		return r;
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel(fill_t fill);
		case (fill)
			FILL_WHITE:  return PIX_W'(PIX_MAX);
			FILL_BLACK:  return '0;
			FILL_BINARY: return $urandom_range(0, 1) ? PIX_W'(PIX_MAX) : '0;
			FILL_BRIGHT: return PIX_W'($urandom_range(PIX_MAX - 8, PIX_MAX));
			default:     return PIX_W'($urandom_range(0, PIX_MAX));
		endcase
	endfunction

	// Call right after a rising edge; returns at the edge that takes the request.
	task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic fs, input logic fl,
			input bit use_fixed, input bit fixed_made, input mean_t fixed_res);
		bit    made;
		mean_t res;
		while (gap_roll()) begin
			pix_if.valid <= 1'b0;
			@(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.pixel_in <= pix;
		pix_if.frame_start <= fs;
		pix_if.flush <= fl;
		@(posedge clk);
		while (!pix_if.ready)
			@(posedge clk);
		predict_mean(pix, fs, fl, made, res);
		if (use_fixed) begin
			made = fixed_made;
			res = fixed_res;
		end
		if (made)
			expected_means.push_back(res);
	endtask

	task automatic drain_means();
		pix_if.valid <= 1'b0;
		while (expected_means.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
		drain_means();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_WIDTH)
			width_reg = data[WIDTH_REG_W-1:0];
		else
			height_reg = data[HEIGHT_REG_W-1:0];
	endtask

	// Send one frame plus its flush requests; a noisy frame is cut short, restarted,
	// over-flushed, under-flushed or begun with a flushed first pixel.
	task automatic send_frame(input fill_t fill, input bit noisy, output int unsigned counted);
		int unsigned total, lag, flushes, stray_at, n;
		bit          fs_on_flush;
		total = eff_width() * eff_height();
		lag = HALF * eff_width() + HALF;
		flushes = lag;
		stray_at = total;
		fs_on_flush = 1'b0;
		if (noisy) begin
			case ($urandom_range(0, 4))
				0: begin
					total = $urandom_range(1, total);
					flushes = $urandom_range(0, lag);
				end
				1: flushes = $urandom_range(0, lag - 1);
				2: flushes = lag + $urandom_range(1, 6);
				3: if (total > 1) stray_at = $urandom_range(1, total - 1);
				default: fs_on_flush = 1'b1;
			endcase
		end
		for (n = 0; n < total; n++)
			push_pixel(pick_pixel(fill), n == 0 || n == stray_at, n == 0 && fs_on_flush,
				1'b0, 1'b0, '0);
		for (n = 0; n < flushes; n++)
			push_pixel(PIX_W'($urandom_range(0, PIX_MAX)), 1'b0, 1'b1, 1'b0, 1'b0, '0);
		counted = total + ((flushes > lag) ? lag : flushes);
	endtask

	initial begin : mean_sink
		mean_t e;
		mean_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (mean_if.valid && mean_if.ready) begin
				if (expected_means.size() == 0) begin
					$display("%0t: unexpected mean: pixel_out %0d frame_last %0b", $time,
						mean_if.pixel_out, mean_if.frame_last);
					mismatch_cnt++;
				end else begin
					e = expected_means.pop_front();
					if (mean_if.pixel_out !== e.pix) begin
						$display("%0t: pixel_out mismatch: expected %0d, actual %0d", $time,
							e.pix, mean_if.pixel_out);
						mismatch_cnt++;
					end
					if (mean_if.frame_last !== e.last) begin
						$display("%0t: frame_last mismatch: expected %0b, actual %0b", $time,
							e.last, mean_if.frame_last);
						mismatch_cnt++;
					end
				end
			end
			mean_if.ready <= !gap_roll();
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		cycle_cnt = 0;
		forever begin
			@(posedge clk);
			cycle_cnt++;
			if ((pix_if.valid && pix_if.ready) || (mean_if.valid && mean_if.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("%0t: no request or mean accepted for %0d cycles", $time, quiet);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int unsigned rand_cnt, got, sel, wv, hv, r;
		fill_t       fill;
		mismatch_cnt = 0;
		pix_if.valid <= 1'b0;
		pix_if.pixel_in <= '0;
		pix_if.frame_start <= 1'b0;
		pix_if.flush <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_WIDTH;
		cfg_data <= '0;
		arst_n <= 1'b0;
		reset_window_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry, then the degenerate 1x1 frame, then a white 5x5 frame
		dir_rows.push_back(pix_row(8'd0, 1'b0, 1'b0));
		dir_rows.push_back(pix_row(8'd255, 1'b0, 1'b0));
		dir_rows.push_back(cfg_row(REG_WIDTH, 12'd0));
		dir_rows.push_back(cfg_row(REG_HEIGHT, 12'd0));
		dir_rows.push_back(fixed_row(8'd255, 1'b1, 1'b1, 1'b0, 8'd0, 1'b0));
		dir_rows.push_back(fixed_row(8'd255, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0));
		dir_rows.push_back(fixed_row(8'h5A, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0));
		dir_rows.push_back(fixed_row(8'hA5, 1'b0, 1'b1, 1'b0, 8'd0, 1'b0));
		dir_rows.push_back(fixed_row(8'hFF, 1'b0, 1'b1, 1'b1, 8'd0, 1'b1));
		dir_rows.push_back(fixed_row(8'h33, 1'b0, 1'b0, 1'b0, 8'd0, 1'b0));
		dir_rows.push_back(cfg_row(REG_WIDTH, 12'd5));
		dir_rows.push_back(cfg_row(REG_HEIGHT, 12'd5));
		for (r = 0; r < 24; r++)
			dir_rows.push_back(pix_row(8'd255, r == 0, 1'b0));
		dir_rows.push_back(fixed_row(8'd255, 1'b0, 1'b0, 1'b1, 8'd255, 1'b0));

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG)
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			else
				push_pixel(dir_rows[i].pix, dir_rows[i].fs, dir_rows[i].fl,
					dir_rows[i].kind == ROW_PIX_FIXED, dir_rows[i].made, dir_rows[i].res);
		end

		// one-pixel-wide tall frame
		write_reg(REG_WIDTH, 12'd1);
		write_reg(REG_HEIGHT, 12'd64);
		send_frame(FILL_BINARY, 1'b0, got);

		rand_cnt = 0;
		while (rand_cnt < RAND_ITEMS) begin
			sel = $urandom_range(0, 9);
			if (sel < 7)
				wv = $urandom_range(5, 16);
			else if (sel < 9)
				wv = $urandom_range(0, 4);
			else
				wv = $urandom_range(17, 40);
			sel = $urandom_range(0, 9);
			if (sel < 7)
				hv = $urandom_range(5, 9);
			else if (sel < 9)
				hv = $urandom_range(0, 4);
			else
				hv = $urandom_range(10, 20);
			if ($urandom_range(0, 4) != 0)
				write_reg(REG_WIDTH, CFG_W'(wv) |
					(CFG_W'($urandom_range(0, 1)) << WIDTH_REG_W));
			if ($urandom_range(0, 4) != 0)
				write_reg(REG_HEIGHT, CFG_W'(hv));
			fill = $urandom_range(0, 1) ? FILL_RANDOM : fill_t'($urandom_range(0, 4));
			send_frame(fill, $urandom_range(0, 3) == 0, got);
			rand_cnt += got;
		end

		drain_means();
		if (mismatch_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
